### sv/sspq_pkg.sv
// ----------------------------------------------------------------------------
// sspq_pkg
// Shared types and codes for the stable sorted priority queue.
// ----------------------------------------------------------------------------
package sspq_pkg;

    // Action codes of an input item
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    // Result status codes
    typedef logic [1:0] t_status;
    localparam t_status STATUS_OK    = 2'd0;
    localparam t_status STATUS_EMPTY = 2'd1;
    localparam t_status STATUS_FULL  = 2'd2;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic ins;   // insert that will be stored
        logic rem;   // remove that will pop the front
    } t_cell_cmd;

endpackage

### sv/sspq_cell.sv
// ----------------------------------------------------------------------------
// sspq_cell
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
// ----------------------------------------------------------------------------
module sspq_cell import sspq_pkg::*; #(
    parameter int PRIORITY_BITS = 8,
    parameter int HANDLE_BITS   = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cell_cmd                i_cmd,
    input  logic [PRIORITY_BITS-1:0] i_new_prio,
    input  logic [HANDLE_BITS-1:0]   i_new_handle,
    // left neighbor (toward the front)
    input  logic                     i_left_stay,
    input  logic                     i_left_valid,
    input  logic [PRIORITY_BITS-1:0] i_left_prio,
    input  logic [HANDLE_BITS-1:0]   i_left_handle,
    // right neighbor (toward the back)
    input  logic                     i_right_valid,
    input  logic [PRIORITY_BITS-1:0] i_right_prio,
    input  logic [HANDLE_BITS-1:0]   i_right_handle,
    output logic                     o_stay,
    output logic                     o_valid,
    output logic [PRIORITY_BITS-1:0] o_prio,
    output logic [HANDLE_BITS-1:0]   o_handle
);

    logic                     r_valid, n_valid;
    logic [PRIORITY_BITS-1:0] r_prio, n_prio;
    logic [HANDLE_BITS-1:0]   r_handle, n_handle;

    // entry stays put on insert when it ranks at or above the new one
    assign o_stay   = r_valid && (r_prio >= i_new_prio);
    assign o_valid  = r_valid;
    assign o_prio   = r_prio;
    assign o_handle = r_handle;

    // next slot contents
    always_comb begin
        n_valid  = r_valid;
        n_prio   = r_prio;
        n_handle = r_handle;
        if (i_cmd.ins) begin
            n_valid = r_valid | i_left_valid;
            if (!o_stay) begin
                if (i_left_stay) begin
                    n_prio   = i_new_prio;
                    n_handle = i_new_handle;
                end else begin
                    n_prio   = i_left_prio;
                    n_handle = i_left_handle;
                end
            end
        end else if (i_cmd.rem) begin
            n_valid  = i_right_valid;
            n_prio   = i_right_prio;
            n_handle = i_right_handle;
        end
    end

    // valid flag is control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_prio   <= n_prio;
        r_handle <= n_handle;
    end

endmodule

### sv/stable_sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue
// Bounded priority queue kept sorted in a chain of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   Drive an item on i_action, i_priority_req and i_rider_handle and raise
//   start; the item is taken at a clock edge where start is high and busy is
//   low. An insert (action 0) places the entry behind every stored entry of
//   greater or equal priority; a remove (action 1) pops the front entry.
//   Every item yields one result, shown for one cycle with o_strobe high,
//   in the cycle right after the item was taken.
//   One item per cycle is sustained while busy is low: all cells compare
//   against the new priority in parallel and each shifts one place left
//   or right, so the whole chain is updated together.
//   Results: o_status (ok, remove on empty, insert on full), the removed
//   o_out_priority / o_out_handle (zero otherwise), o_is_empty, o_occupancy.
//   A full insert is dropped; an empty remove leaves the queue unchanged.
//   Reset (synchronous, active low) empties the queue; busy is high for the
//   first cycle after reset and low from then on.
//   The receiver cannot stall: each result must be taken in its cycle.
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue import sspq_pkg::*; #(
    parameter int CAPACITY      = 16,
    parameter int PRIORITY_BITS = 8,
    parameter int HANDLE_BITS   = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_action,
    input  logic [PRIORITY_BITS-1:0]         i_priority_req,
    input  logic [HANDLE_BITS-1:0]           i_rider_handle,
    output logic                             o_strobe,
    output t_status                          o_status,
    output logic [PRIORITY_BITS-1:0]         o_out_priority,
    output logic [HANDLE_BITS-1:0]           o_out_handle,
    output logic                             o_is_empty,
    output logic [$clog2(CAPACITY+1)-1:0]    o_occupancy
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                     r_busy;
    logic [CNT_W-1:0]         r_count, n_count;
    logic                     accept;
    logic                     full, empty;
    t_cell_cmd                cmd;
    t_status                  n_status;

    logic                     r_strobe;
    t_status                  r_status;
    logic [PRIORITY_BITS-1:0] r_out_prio;
    logic [HANDLE_BITS-1:0]   r_out_handle;
    logic                     r_empty;
    logic [CNT_W-1:0]         r_occ;

    // neighbor links of the chain
    logic                     c_stay   [CAPACITY];
    logic                     c_valid  [CAPACITY];
    logic [PRIORITY_BITS-1:0] c_prio   [CAPACITY];
    logic [HANDLE_BITS-1:0]   c_handle [CAPACITY];

    assign accept = start && !r_busy;
    assign busy   = r_busy;
    assign full   = (r_count == CNT_W'(CAPACITY));
    assign empty  = (r_count == '0);

    // decode the item into a cell command and status
    always_comb begin
        cmd      = '0;
        n_status = STATUS_OK;
        n_count  = r_count;
        if (accept) begin
            if (i_action == ACT_INSERT) begin
                if (full) begin
                    n_status = STATUS_FULL;
                end else begin
                    cmd.ins = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end else begin
                if (empty) begin
                    n_status = STATUS_EMPTY;
                end else begin
                    cmd.rem = 1'b1;
                    n_count = r_count - 1'b1;
                end
            end
        end
    end

    // slot cells, slot 0 is the front
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                     left_stay, left_valid, right_valid;
        logic [PRIORITY_BITS-1:0] left_prio, right_prio;
        logic [HANDLE_BITS-1:0]   left_handle, right_handle;

        if (g == 0) begin : g_front
            assign left_stay   = 1'b1;
            assign left_valid  = 1'b1;
            assign left_prio   = i_priority_req;
            assign left_handle = i_rider_handle;
        end else begin : g_mid
            assign left_stay   = c_stay[g-1];
            assign left_valid  = c_valid[g-1];
            assign left_prio   = c_prio[g-1];
            assign left_handle = c_handle[g-1];
        end

        if (g == CAPACITY - 1) begin : g_back
            assign right_valid  = 1'b0;
            assign right_prio   = '0;
            assign right_handle = '0;
        end else begin : g_inner
            assign right_valid  = c_valid[g+1];
            assign right_prio   = c_prio[g+1];
            assign right_handle = c_handle[g+1];
        end

        sspq_cell #(
            .PRIORITY_BITS (PRIORITY_BITS),
            .HANDLE_BITS   (HANDLE_BITS)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_cmd          (cmd),
            .i_new_prio     (i_priority_req),
            .i_new_handle   (i_rider_handle),
            .i_left_stay    (left_stay),
            .i_left_valid   (left_valid),
            .i_left_prio    (left_prio),
            .i_left_handle  (left_handle),
            .i_right_valid  (right_valid),
            .i_right_prio   (right_prio),
            .i_right_handle (right_handle),
            .o_stay         (c_stay[g]),
            .o_valid        (c_valid[g]),
            .o_prio         (c_prio[g]),
            .o_handle       (c_handle[g])
        );
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b1;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_busy   <= 1'b0;
            r_count  <= n_count;
            r_strobe <= accept;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        r_status     <= n_status;
        r_out_prio   <= cmd.rem ? c_prio[0] : '0;
        r_out_handle <= cmd.rem ? c_handle[0] : '0;
        r_empty      <= (n_count == '0);
        r_occ        <= n_count;
    end

    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_out_priority = r_out_prio;
    assign o_out_handle   = r_out_handle;
    assign o_is_empty     = r_empty;
    assign o_occupancy    = r_occ;

endmodule

### tb/sv/stable_sorted_priority_queue_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_tb
// Self-checking bench for the stable sorted priority queue.
// A mirror of the sorted slot array predicts the result of every item that
// the block takes. Each strobed result is checked against the oldest
// prediction. Stimulus is a short directed run (remove on empty, extremes,
// ties, insert on full), followed by random phases. The phases are biased
// toward filling, draining or balance, with bursty issue and a drain pause
// after each phase.
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue_tb;
    import sspq_pkg::*;

    localparam int CAPACITY    = 16;
    localparam int PRI_W       = 8;
    localparam int HDL_W       = 16;
    localparam int OCC_W       = $clog2(CAPACITY + 1);
    localparam int HALF_PERIOD = 4;
    localparam int RESET_CYCLES = 9;
    localparam int RAND_ITEMS  = 700;
    localparam int SETTLE_CYCLES = 3;
    localparam int QUIET_LIMIT = 256;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        t_status            status;
        logic [PRI_W-1:0]   pri;
        logic [HDL_W-1:0]   hdl;
        logic               empty;
        logic [OCC_W-1:0]   occ;
    } t_queue_result;

    // ------------------------------------------------------------------------
    // Mirror of the slot array plus the results it still waits for
    // ------------------------------------------------------------------------
    class sorted_queue_mirror;
        logic [PRI_W-1:0] slot_pri [CAPACITY];
        logic [HDL_W-1:0] slot_hdl [CAPACITY];
        int               count;
        t_queue_result    awaited_results [$];
        int               mismatches;
        int               checked;
        int               n_insert;
        int               n_remove;
        int               n_full;
        int               n_empty;
        int               peak_occ;

        function new();
            count      = 0;
            mismatches = 0;
            checked    = 0;
            n_insert   = 0;
            n_remove   = 0;
            n_full     = 0;
            n_empty    = 0;
            peak_occ   = 0;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("%s", msg);
        endfunction

        // Apply one accepted item and queue up the result it must give
        function void take_item(logic act, logic [PRI_W-1:0] pri, logic [HDL_W-1:0] hdl);
            t_queue_result res;
            int            pos;
            int            k;
            res = '0;
            res.status = STATUS_OK;
            if (act == ACT_INSERT) begin
                n_insert++;
                if (count >= CAPACITY) begin
                    res.status = STATUS_FULL;
                    n_full++;
                end else begin
                    // stable: go behind every entry of greater or equal priority
                    pos = 0;
                    while (pos < count && slot_pri[pos] >= pri)
                        pos++;
                    for (k = count; k > pos; k--) begin
                        slot_pri[k] = slot_pri[k-1];
                        slot_hdl[k] = slot_hdl[k-1];
                    end
                    slot_pri[pos] = pri;
                    slot_hdl[pos] = hdl;
                    count++;
                end
            end else begin
                n_remove++;
                if (count == 0) begin
                    res.status = STATUS_EMPTY;
                    n_empty++;
                end else begin
                    res.pri = slot_pri[0];
                    res.hdl = slot_hdl[0];
                    for (k = 0; k + 1 < count; k++) begin
                        slot_pri[k] = slot_pri[k+1];
                        slot_hdl[k] = slot_hdl[k+1];
                    end
                    count--;
                end
            end
            if (count > peak_occ)
                peak_occ = count;
            res.empty = (count == 0);
            res.occ   = OCC_W'(count);
            awaited_results.push_back(res);
        endfunction

        // Compare one strobed result with the oldest prediction
        function void check_result(t_queue_result got);
            t_queue_result want;
            if (awaited_results.size() == 0) begin
                flag($sformatf("unexpected result: status=%0d pri=%0h hdl=%0h empty=%0b occ=%0d",
                               got.status, got.pri, got.hdl, got.empty, got.occ));
                return;
            end
            want = awaited_results.pop_front();
            checked++;
            if (got.status !== want.status || got.pri !== want.pri || got.hdl !== want.hdl ||
                got.empty !== want.empty || got.occ !== want.occ)
                flag($sformatf({"result %0d: exp status=%0d pri=%0h hdl=%0h empty=%0b occ=%0d",
                                " | got status=%0d pri=%0h hdl=%0h empty=%0b occ=%0d"},
                               checked, want.status, want.pri, want.hdl, want.empty, want.occ,
                               got.status, got.pri, got.hdl, got.empty, got.occ));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs
    // ------------------------------------------------------------------------
    logic             i_clk          = 1'b0;
    logic             i_rst_n        = 1'b0;
    logic             start          = 1'b0;
    logic             i_action       = ACT_INSERT;
    logic [PRI_W-1:0] i_priority_req = '0;
    logic [HDL_W-1:0] i_rider_handle = '0;

    logic             busy;
    logic             o_strobe;
    t_status          o_status;
    logic [PRI_W-1:0] o_out_priority;
    logic [HDL_W-1:0] o_out_handle;
    logic             o_is_empty;
    logic [OCC_W-1:0] o_occupancy;

    sorted_queue_mirror mirror = new();
    int                 quiet_cycles = 0;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    stable_sorted_priority_queue #(
        .CAPACITY      (CAPACITY),
        .PRIORITY_BITS (PRI_W),
        .HANDLE_BITS   (HDL_W)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_priority_req (i_priority_req),
        .i_rider_handle (i_rider_handle),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_out_priority (o_out_priority),
        .o_out_handle   (o_out_handle),
        .o_is_empty     (o_is_empty),
        .o_occupancy    (o_occupancy)
    );

    // ------------------------------------------------------------------------
    // Monitor: check results, record accepted items, watchdog
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_queue_result got;
        logic          taken;
        taken = (start === 1'b1 && busy === 1'b0);
        if (o_strobe === 1'b1) begin
            got.status = o_status;
            got.pri    = o_out_priority;
            got.hdl    = o_out_handle;
            got.empty  = o_is_empty;
            got.occ    = o_occupancy;
            mirror.check_result(got);
        end
        if (taken)
            mirror.take_item(i_action, i_priority_req, i_rider_handle);
        // watchdog on cycles with no item taken
        if (taken)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no item taken for %0d cycles", QUIET_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks, all entered right after a rising edge
    // ------------------------------------------------------------------------
    task automatic send_item(input logic act, input logic [PRI_W-1:0] pri,
                             input logic [HDL_W-1:0] hdl);
        start          <= 1'b1;
        i_action       <= act;
        i_priority_req <= pri;
        i_rider_handle <= hdl;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // hold off until every predicted result has come back
    task automatic wait_results_done();
        start <= 1'b0;
        do @(posedge i_clk); while (mirror.awaited_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic             act;
        logic [PRI_W-1:0] pri;
        logic [HDL_W-1:0] hdl;
        int               i;
        int               items_left;
        int               phase_len;
        int               mode;
        int               pri_style;
        int               burst_left;
        bit               no_gap;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed: remove on empty with all-ones ignored fields
        send_item(ACT_REMOVE, '1, '1);
        // extremes of priority and handle
        send_item(ACT_INSERT, '0, '1);
        send_item(ACT_INSERT, '1, '0);
        // fill with two tied priority groups; handles give arrival order
        for (i = 0; i < CAPACITY - 2; i++)
            send_item(ACT_INSERT, (i % 2) ? 8'hAA : 8'h55, HDL_W'(i + 1));
        // insert on full queue is dropped
        send_item(ACT_INSERT, '1, 16'hBEEF);
        repeat (4) send_item(ACT_REMOVE, '0, '0);
        wait_results_done();

        // random phases
        items_left = RAND_ITEMS;
        while (items_left > 0) begin
            phase_len = $urandom_range(30, 110);
            if (phase_len > items_left)
                phase_len = items_left;
            mode       = $urandom_range(0, 2);
            pri_style  = $urandom_range(0, 3);
            no_gap     = ($urandom_range(0, 4) == 0);
            burst_left = 0;
            repeat (phase_len) begin
                if (burst_left == 0) begin
                    if (!no_gap && $urandom_range(0, 3) != 0)
                        idle_cycles($urandom_range(1, 6));
                    burst_left = $urandom_range(1, 16);
                end
                // fill-heavy, drain-heavy or balanced mix
                case (mode)
                    0:       act = $urandom_range(0, 1) ? ACT_REMOVE : ACT_INSERT;
                    1:       act = ($urandom_range(0, 99) < 85) ? ACT_INSERT : ACT_REMOVE;
                    default: act = ($urandom_range(0, 99) < 85) ? ACT_REMOVE : ACT_INSERT;
                endcase
                // wide spread, dense ties, extremes only, or coarse steps
                case (pri_style)
                    0:       pri = PRI_W'($urandom_range(0, 255));
                    1:       pri = PRI_W'($urandom_range(120, 123));
                    2:       pri = $urandom_range(0, 1) ? '1 : '0;
                    default: pri = PRI_W'($urandom_range(0, 7) << 5);
                endcase
                hdl = HDL_W'($urandom);
                send_item(act, pri, hdl);
                burst_left--;
            end
            items_left -= phase_len;
            wait_results_done();
        end

        // wrap up
        if (mirror.awaited_results.size() != 0)
            mirror.flag($sformatf("%0d predicted results never came",
                                  mirror.awaited_results.size()));
        $display("covered %0d inserts (%0d dropped on full), %0d removes (%0d on empty), peak %0d",
                 mirror.n_insert, mirror.n_full, mirror.n_remove, mirror.n_empty,
                 mirror.peak_occ);
        $display("checked %0d results, %0d mismatches", mirror.checked, mirror.mismatches);
        if (mirror.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
